// ----- rtl/core/hkrf_pkg.sv -----
// Shared types, constants and the key code map for the HID keyboard report framer.
// No dependencies; the front and back modules import it.
`default_nettype none

package hkrf_pkg;

    // Default depth of the held key set
    localparam int MAX_KEYS_DEF = 6;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Event actions
    localparam logic [1:0] ACT_DOWN    = 2'd0;
    localparam logic [1:0] ACT_UP      = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    // Frame layout
    localparam int             FRAME_LEN  = 14;
    localparam int             FRAME_KEYS = 6;
    localparam logic [3:0]     POS_MOD    = 4'd5;
    localparam logic [3:0]     POS_KEY0   = 4'd7;
    localparam logic [3:0]     POS_SUM    = 4'd13;
    localparam logic [7:0]     HDR_SYNC0  = 8'h57;
    localparam logic [7:0]     HDR_SYNC1  = 8'hAB;
    localparam logic [7:0]     HDR_ADDR   = 8'h00;
    localparam logic [7:0]     HDR_CMD    = 8'h02;
    localparam logic [7:0]     HDR_LEN    = 8'h08;
    localparam logic [7:0]     BYTE_ZERO  = 8'h00;

    // Usages that are modifiers and never enter the set
    localparam logic [7:0] USAGE_CTRL  = 8'h01;
    localparam logic [7:0] USAGE_SHIFT = 8'h02;

    // Offset bases
    localparam logic [7:0] BASE_LETTER = 8'h04;
    localparam logic [7:0] BASE_DIGIT  = 8'h1E;
    localparam logic [7:0] USAGE_ZERO  = 8'h27;
    localparam logic [7:0] BASE_KPAD   = 8'h59;
    localparam logic [7:0] USAGE_KP0   = 8'h62;
    localparam logic [7:0] BASE_FKEY   = 8'h3A;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } t_op;

    // Classified event passed from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] usage;
        logic [3:0] mod;
    } t_cmd;

    // Map a virtual-key code to {hit, usage}; hit low means no usage
    function automatic logic [8:0] map_usage(input logic [7:0] vk);
        logic [8:0] res;
        res = 9'h000;
        if (vk >= 8'd65 && vk <= 8'd90) begin
            res = {1'b1, BASE_LETTER + (vk - 8'd65)};
        end else if (vk == 8'd48) begin
            res = {1'b1, USAGE_ZERO};
        end else if (vk >= 8'd49 && vk <= 8'd57) begin
            res = {1'b1, BASE_DIGIT + (vk - 8'd49)};
        end else if (vk == 8'd96) begin
            res = {1'b1, USAGE_KP0};
        end else if (vk >= 8'd97 && vk <= 8'd105) begin
            res = {1'b1, BASE_KPAD + (vk - 8'd97)};
        end else if (vk >= 8'd112 && vk <= 8'd123) begin
            res = {1'b1, BASE_FKEY + (vk - 8'd112)};
        end else begin
            case (vk)
                8'd27:   res = {1'b1, 8'h29};
                8'd8:    res = {1'b1, 8'h2A};
                8'd9:    res = {1'b1, 8'h2B};
                8'd20:   res = {1'b1, 8'h39};
                8'd13:   res = {1'b1, 8'h28};
                8'd16:   res = {1'b1, USAGE_SHIFT};
                8'd17:   res = {1'b1, USAGE_CTRL};
                8'd32:   res = {1'b1, 8'h2C};
                8'd45:   res = {1'b1, 8'h49};
                8'd46:   res = {1'b1, 8'h4C};
                8'd36:   res = {1'b1, 8'h4A};
                8'd35:   res = {1'b1, 8'h4D};
                8'd33:   res = {1'b1, 8'h4B};
                8'd34:   res = {1'b1, 8'h4E};
                8'd37:   res = {1'b1, 8'h50};
                8'd38:   res = {1'b1, 8'h52};
                8'd39:   res = {1'b1, 8'h4F};
                8'd40:   res = {1'b1, 8'h51};
                8'd144:  res = {1'b1, 8'h53};
                8'd192:  res = {1'b1, 8'h35};
                8'd189:  res = {1'b1, 8'h2D};
                8'd187:  res = {1'b1, 8'h2E};
                8'd219:  res = {1'b1, 8'h2F};
                8'd221:  res = {1'b1, 8'h30};
                8'd186:  res = {1'b1, 8'h33};
                8'd222:  res = {1'b1, 8'h34};
                8'd220:  res = {1'b1, 8'h31};
                8'd188:  res = {1'b1, 8'h36};
                8'd190:  res = {1'b1, 8'h37};
                8'd191:  res = {1'b1, 8'h38};
                8'd111:  res = {1'b1, 8'h38};
                8'd106:  res = {1'b1, 8'h55};
                8'd109:  res = {1'b1, 8'h56};
                8'd107:  res = {1'b1, 8'h57};
                8'd110:  res = {1'b1, 8'h63};
                8'd91:   res = {1'b1, 8'h08};
                default: res = 9'h000;
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hid_keyboard_report_framer.sv -----
// Top level of the HID keyboard report framer: front classifier and queue,
// back set update and frame streamer. Depends on hkrf_pkg, hkrf_front, hkrf_back.
`default_nettype none

// Each accepted key event (down, up, release all) produces one 14-byte boot
// keyboard frame: 57 AB 00 02 08, modifier byte, 00, six ascending key
// usages padded with 00, and an 8-bit sum of the preceding 13 bytes; o_last
// marks the checksum byte. Action 3 is accepted and produces nothing. Up to
// MAX_KEYS usages are held; only the lowest six appear in a frame. The back
// end emits one frame byte per clock while the consumer pops every cycle;
// the set update for the next event, if already queued, happens in the same
// cycle as the checksum byte of the current one. A two-entry command queue
// lets up to two events be accepted ahead of the frame in progress, plus a
// one-byte output register.
module hid_keyboard_report_framer
    import hkrf_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_key_code,
    input  wire logic [3:0] i_modifier_flags,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_frame_byte,
    output logic            o_last
);

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    // Classify and queue events
    hkrf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_key_code       (i_key_code),
        .i_modifier_flags (i_modifier_flags),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_take       (cmd_take)
    );

    // Update the key set and stream frames
    hkrf_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_take   (cmd_take),
        .empty        (empty),
        .pop          (pop),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/hkrf_front.sv -----
// Front end: accepts key events, classifies them into set commands and
// queues them for the back end. Depends on hkrf_pkg.
`default_nettype none

module hkrf_front
    import hkrf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_key_code,
    input  wire logic [3:0] i_modifier_flags,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  wire logic       i_cmd_take
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    t_cmd          cmd_new;
    logic [8:0]    map_res;
    logic          accept, wr, rd;

    // Classify the incoming event
    always_comb begin
        map_res       = map_usage(i_key_code);
        cmd_new.usage = map_res[7:0];
        cmd_new.mod   = {i_modifier_flags[0], i_modifier_flags[1],
                         i_modifier_flags[2], i_modifier_flags[3]};
        if (i_action == ACT_RELEASE) begin
            cmd_new.op = OP_CLEAR;
        end else if (!map_res[8] || map_res[7:0] == USAGE_CTRL
                     || map_res[7:0] == USAGE_SHIFT) begin
            cmd_new.op = OP_NONE;
        end else if (i_action == ACT_DOWN) begin
            cmd_new.op = OP_INSERT;
        end else begin
            cmd_new.op = OP_REMOVE;
        end
    end

    assign full        = (r_cnt == CW'(QUEUE_DEPTH));
    assign accept      = push && !full;
    // Drop the unused action: accepted, no frame
    assign wr          = accept && (i_action != ACT_UNUSED);
    assign rd          = i_cmd_take && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_new;
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_DEPTH))
        else $error("command queue overfilled");

endmodule

`default_nettype wire

// ----- rtl/core/hkrf_back.sv -----
// Back end: applies set commands to the sorted held key set and streams
// the 14-byte frame with a running checksum. Depends on hkrf_pkg.
`default_nettype none

module hkrf_back
    import hkrf_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_take,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_frame_byte,
    output logic            o_last
);

    localparam int CW = $clog2(MAX_KEYS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state        r_state;
    logic [3:0]    r_idx;
    logic [3:0]    r_mod;
    logic [7:0]    r_sum;
    logic [7:0]    r_keys [MAX_KEYS];
    logic [CW-1:0] r_count;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_valid;

    logic [7:0]    n_keys [MAX_KEYS];
    logic [CW-1:0] n_count;
    logic [7:0]    key_prev [MAX_KEYS];
    logic [7:0]    key_next [MAX_KEYS];
    logic [MAX_KEYS-1:0] lt, hit, after;
    logic [MAX_KEYS:0]   lt_ext;
    logic          present;
    logic [7:0]    fk [FRAME_KEYS];
    logic [7:0]    byte_sel;
    logic [2:0]    kidx;
    logic          load, take, at_end;

    // Neighbor views of the set for shifting
    always_comb begin
        key_prev[0]          = BYTE_ZERO;
        key_next[MAX_KEYS-1] = BYTE_ZERO;
        for (int i = 0; i < MAX_KEYS - 1; i++) begin
            key_prev[i+1] = r_keys[i];
            key_next[i]   = r_keys[i+1];
        end
    end

    // Compare the command usage against every held entry
    always_comb begin
        for (int i = 0; i < MAX_KEYS; i++) begin
            lt[i]  = (CW'(i) < r_count) && (r_keys[i] < i_cmd.usage);
            hit[i] = (CW'(i) < r_count) && (r_keys[i] == i_cmd.usage);
        end
        lt_ext   = {lt, 1'b1};
        present  = |hit;
        after[0] = hit[0];
        for (int i = 1; i < MAX_KEYS; i++) begin
            after[i] = after[i-1] | hit[i];
        end
    end

    // Next set contents for the command
    always_comb begin
        n_keys  = r_keys;
        n_count = r_count;
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (!present && r_count != CW'(MAX_KEYS)) begin
                    for (int i = 0; i < MAX_KEYS; i++) begin
                        if (lt[i]) begin
                            n_keys[i] = r_keys[i];
                        end else if (lt_ext[i]) begin
                            n_keys[i] = i_cmd.usage;
                        end else begin
                            n_keys[i] = key_prev[i];
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (present) begin
                    for (int i = 0; i < MAX_KEYS; i++) begin
                        n_keys[i] = after[i] ? key_next[i] : r_keys[i];
                    end
                    n_count = r_count - 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < MAX_KEYS; i++) begin
                    n_keys[i] = BYTE_ZERO;
                end
                n_count = '0;
            end
            OP_NONE: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Key bytes of the frame, zero past the fill count
    for (genvar k = 0; k < FRAME_KEYS; k++) begin : g_fk
        if (k < MAX_KEYS) begin : g_held
            assign fk[k] = (CW'(k) < r_count) ? r_keys[k] : BYTE_ZERO;
        end else begin : g_pad
            assign fk[k] = BYTE_ZERO;
        end
    end

    // Select the current frame byte
    always_comb begin
        kidx = 3'(r_idx - POS_KEY0);
        if (r_idx == POS_SUM) begin
            byte_sel = r_sum;
        end else if (r_idx >= POS_KEY0) begin
            byte_sel = (kidx < 3'(FRAME_KEYS)) ? fk[kidx] : BYTE_ZERO;
        end else if (r_idx == POS_MOD) begin
            byte_sel = {4'h0, r_mod};
        end else begin
            unique case (r_idx[2:0])
                3'd0:    byte_sel = HDR_SYNC0;
                3'd1:    byte_sel = HDR_SYNC1;
                3'd2:    byte_sel = HDR_ADDR;
                3'd3:    byte_sel = HDR_CMD;
                3'd4:    byte_sel = HDR_LEN;
                default: byte_sel = BYTE_ZERO;
            endcase
        end
    end

    assign load       = (r_state == ST_SEND) && (!r_out_valid || pop);
    assign at_end     = (r_idx == POS_SUM);
    assign take       = i_cmd_valid && ((r_state == ST_IDLE) || (load && at_end));
    assign o_cmd_take = take;

    assign empty        = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last       = r_out_last;

    // Sequence frames: pick up a command, update the set, emit bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_KEYS; i++) begin
                r_keys[i] <= BYTE_ZERO;
            end
        end else begin
            // Load the next frame byte, or drop the one just popped
            if (load) begin
                r_out_byte  <= byte_sel;
                r_out_last  <= at_end;
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            // Start the next frame, or advance through the current one
            if (take) begin
                r_keys  <= n_keys;
                r_count <= n_count;
                r_mod   <= i_cmd.mod;
                r_idx   <= '0;
                r_sum   <= '0;
                r_state <= ST_SEND;
            end else if (load) begin
                r_sum <= r_sum + byte_sel;
                r_idx <= r_idx + 1'b1;
                if (at_end) begin
                    r_state <= ST_IDLE;
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEYS))
        else $error("held key count above capacity");

    a_last_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_state == ST_IDLE || r_idx == '0))
        else $error("frame end not aligned with byte counter");

    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_idx == '0) |=> (r_out_byte == HDR_SYNC0 && !r_out_last))
        else $error("frame does not open with sync byte");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_state == ST_SEND) |-> (load && at_end))
        else $error("command taken in the middle of a frame");

    for (genvar g = 0; g + 1 < MAX_KEYS; g++) begin : g_sorted
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (CW'(g + 1) < r_count) |-> (r_keys[g] < r_keys[g+1]))
            else $error("held keys out of order");
    end

endmodule

`default_nettype wire
